FILE: sv/pwd_pkg.sv
// ============================================================================
// pwd_pkg
// Types and constants shared by the dual progress watchdog.
// ============================================================================
package pwd_pkg;

  localparam int CountWidth = 31;
  localparam int CfgWidth   = 16;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;

  localparam logic [CountWidth-1:0] StallMax = {CountWidth{1'b1}};

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] RegServerCheckPeriod = 2'd0;
  localparam logic [1:0] RegNodeStallLimit    = 2'd1;
  localparam logic [1:0] RegServerStallLimit  = 2'd2;

  typedef struct packed {
    logic [CountWidth-1:0] node_count;
    logic [CountWidth-1:0] server_count;
  } tick_t;

  typedef struct packed {
    logic                  node_stalled;
    logic                  server_checked;
    logic                  server_stalled;
    logic                  reboot;
    logic [CountWidth-1:0] node_stall_total;
    logic [CountWidth-1:0] server_stall_total;
  } status_t;

endpackage

FILE: sv/progress_watchdog_dual.sv
// ============================================================================
// progress_watchdog_dual
// Two-source progress watchdog: counts node and server stalls per tick,
// examines the server on a configurable period and flags reboot.
// ============================================================================
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   tick     | tick_valid/stall     | node_count, server_count
//   status   | status_valid/stall   | stall flags, reboot, stall totals
//   config   | APB write/read       | period and two stall limits
//
// When the server period is zero a tick skips the divider; otherwise
// a restoring divider retires one bit of the 32-bit check counter per
// cycle to form its remainder modulo the period.
// A new tick is taken only once the previous one has finished; the status
// register holds its transfer while status_stall is high, and a finished
// tick waits in place until the status register is free.
// rst is synchronous: it zeroes config, counts and status_valid, state to S_IDLE.
module progress_watchdog_dual (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_stall,
  input  pwd_pkg::tick_t                 tick,
  output logic                           status_valid,
  input  logic                           status_stall,
  output pwd_pkg::status_t               status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pwd_pkg::AddrWidth-1:0]  paddr,
  input  logic [pwd_pkg::DataWidth-1:0]  pwdata,
  output logic [pwd_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);
  import pwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIV    = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [CfgWidth-1:0]   server_check_period;
  logic [CfgWidth-1:0]   node_stall_limit;
  logic [CfgWidth-1:0]   server_stall_limit;

  logic [CountWidth:0]   last_node;
  logic [CountWidth-1:0] last_server;
  logic [CountWidth:0]   check_count;
  logic [CountWidth-1:0] node_stalls;
  logic [CountWidth-1:0] server_stalls;

  logic [CountWidth-1:0] server_hold;
  logic                  node_stall_hold;
  logic [CountWidth:0]   dividend;
  logic [CfgWidth-1:0]   rem;
  logic [4:0]            bit_cnt;

  logic                  tick_take;
  logic                  node_progress;
  logic [CountWidth:0]   check_count_next;
  logic [CfgWidth:0]     rem_sh;
  logic [CfgWidth:0]     rem_diff;
  logic                  rem_ge;
  logic [CfgWidth-1:0]   rem_next;
  logic                  finish_ok;
  logic                  srv_check;
  logic                  srv_stall;
  logic [CountWidth-1:0] server_stalls_next;
  logic [CountWidth-1:0] node_stalls_sat;
  logic                  reboot_now;
  logic                  cfg_write;

  assign pready     = 1'b1;
  assign tick_stall = (state != S_IDLE);
  assign tick_take  = tick_valid && !tick_stall;
  assign cfg_write  = psel && penable && pwrite && pready;

  assign node_progress    = {1'b0, tick.node_count} > last_node;
  assign check_count_next = node_progress ? {1'b0, tick.node_count} : check_count;
  assign node_stalls_sat  = (node_stalls == StallMax) ? node_stalls
                                                      : node_stalls + 1'b1;

  // Restoring divide step: one remainder bit per cycle.
  assign rem_sh   = {rem, dividend[CountWidth]};
  assign rem_diff = rem_sh - {1'b0, server_check_period};
  assign rem_ge   = rem_sh >= {1'b0, server_check_period};
  assign rem_next = rem_ge ? rem_diff[CfgWidth-1:0] : rem_sh[CfgWidth-1:0];

  assign finish_ok = !status_valid || !status_stall;
  assign srv_check = (server_check_period == '0) || (rem == CfgWidth'(1));
  assign srv_stall = srv_check && !(server_hold > last_server);
  assign server_stalls_next = !srv_stall ? server_stalls :
                              (server_stalls == StallMax) ? server_stalls
                                                          : server_stalls + 1'b1;
  assign reboot_now =
      ((node_stall_limit != '0) && (node_stalls > CountWidth'(node_stall_limit))) ||
      ((server_stall_limit != '0) &&
       (server_stalls_next > CountWidth'(server_stall_limit)));

  always_comb begin
    unique case (paddr[3:2])
      RegServerCheckPeriod: prdata = DataWidth'(server_check_period);
      RegNodeStallLimit:    prdata = DataWidth'(node_stall_limit);
      RegServerStallLimit:  prdata = DataWidth'(server_stall_limit);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_check_period <= '0;
      node_stall_limit    <= '0;
      server_stall_limit  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        RegServerCheckPeriod: server_check_period <= pwdata[CfgWidth-1:0];
        RegNodeStallLimit:    node_stall_limit    <= pwdata[CfgWidth-1:0];
        RegServerStallLimit:  server_stall_limit  <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      status_valid  <= 1'b0;
      last_node     <= '0;
      last_server   <= '0;
      check_count   <= '0;
      node_stalls   <= '0;
      server_stalls <= '0;
    end else begin
      // In the finishing cycle the status register is reloaded instead.
      if (status_valid && !status_stall && (state != S_FINISH)) begin
        status_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_take) begin
            server_hold     <= tick.server_count;
            node_stall_hold <= !node_progress;
            check_count     <= check_count_next;
            dividend        <= check_count_next;
            rem             <= '0;
            bit_cnt         <= '1;
            if (node_progress) begin
              last_node <= {1'b0, tick.node_count};
            end else begin
              last_node   <= {1'b0, tick.node_count} + 1'b1;
              node_stalls <= node_stalls_sat;
            end
            state <= (server_check_period == '0) ? S_FINISH : S_DIV;
          end
        end
        S_DIV: begin
          rem      <= rem_next;
          dividend <= {dividend[CountWidth-1:0], 1'b0};
          bit_cnt  <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_ok) begin
            if (srv_check && !srv_stall) begin
              last_server <= server_hold;
            end
            server_stalls <= server_stalls_next;
            check_count   <= check_count + 1'b1;
            status_valid  <= 1'b1;
            status.node_stalled       <= node_stall_hold;
            status.server_checked     <= srv_check;
            status.server_stalled     <= srv_stall;
            status.reboot             <= reboot_now;
            status.node_stall_total   <= node_stalls;
            status.server_stall_total <= server_stalls_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
